// ===== hdl/sobel_pkg.sv =====
// Shared constants and types for the Sobel edge threshold unit.
// No dependencies; imported by sobel_edge_threshold_unit.
`timescale 1ns / 1ps

package sobel_pkg;

  localparam int MaxWidthDefault = 2048;

  localparam int PixW = 8;
  localparam int ThrW = 11;
  localparam int DimW = 12;
  localparam int ColOutW = 11;
  localparam int RowOutW = 12;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 12;
  localparam int GradW = 11;
  localparam int SqW = 20;
  localparam int ThrSqW = 22;

  localparam logic [CfgIdxW-1:0] CfgEdgeThreshold = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgImageWidth = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgImageHeight = 2'd2;

  localparam logic [ThrW-1:0] ThresholdReset = 11'd155;
  localparam logic [DimW-1:0] WidthReset = 12'd640;
  localparam logic [DimW-1:0] HeightReset = 12'd480;
  localparam logic [DimW-1:0] MinDim = 12'd3;

  localparam logic [PixW-1:0] EdgeOn = 8'd255;
  localparam logic [PixW-1:0] EdgeOff = 8'd0;

  typedef logic [PixW-1:0] pixel_t;

endpackage

// ===== hdl/sobel_edge_threshold_unit.sv =====
// Sobel 3x3 edge detector with magnitude threshold, top level.
// Depends on sobel_pkg.
`timescale 1ns / 1ps

// Takes one pixel per clock in raster order while in_stall_o is low and
// gives, for every interior pixel, 255 when gx^2 + gy^2 exceeds the squared
// threshold, else 0, with the center column/row and a frame-last flag. Border
// pixels give no result. Throughput is one pixel per cycle without stalls;
// the single line memory (two rows packed in one word) is read at accept and
// written back when stage 1 moves on. The line memory needs no clearing pass;
// geometry registers may only be written while idle.
module sobel_edge_threshold_unit
  import sobel_pkg::*;
#(
  parameter int MAX_WIDTH = MaxWidthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [PixW-1:0]     pixel_value_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [PixW-1:0]     edge_value_o,
  output logic [ColOutW-1:0]  center_col_o,
  output logic [RowOutW-1:0]  center_row_o,
  output logic                frame_last_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WEW = $clog2(MAX_WIDTH + 1);

  // configuration
  logic [ThrW-1:0]   threshold_q;
  logic [DimW-1:0]   image_width_q;
  logic [DimW-1:0]   image_height_q;
  logic [ThrSqW-1:0] thr_sq_q;

  // raster position
  logic [CW-1:0]   col_q, col_d;
  logic [DimW-1:0] row_q, row_d;
  logic [WEW-1:0]  w_eff;
  logic [DimW-1:0] h_eff;
  logic            col_wrap;
  logic [DimW:0]   row_tmp;
  logic [DimW:0]   row_inc;
  logic [CW-1:0]   cur_col;
  logic [DimW-1:0] cur_row;
  logic [WEW-1:0]  col_inc;
  logic            cur_has;
  logic            cur_last;

  // line memory: [15:8] two rows up, [7:0] one row up
  logic [2*PixW-1:0] line_mem [MAX_WIDTH];
  logic [2*PixW-1:0] rd_q;

  // stage 1
  logic               s1_v_q;
  logic               s1_has_q;
  logic               s1_last_q;
  pixel_t             s1_px_q;
  logic [CW-1:0]      s1_col_q;
  logic [ColOutW-1:0] s1_ccol_q;
  logic [RowOutW-1:0] s1_crow_q;

  // window
  pixel_t win_q [9];
  pixel_t win_d [9];
  logic signed [GradW-1:0] gx_d, gy_d;

  // stage 2
  logic                    s2_v_q;
  logic                    s2_last_q;
  logic [ColOutW-1:0]      s2_ccol_q;
  logic [RowOutW-1:0]      s2_crow_q;
  logic signed [GradW-1:0] s2_gx_q, s2_gy_q;

  // stage 3
  logic                    s3_v_q;
  logic                    s3_last_q;
  logic [ColOutW-1:0]      s3_ccol_q;
  logic [RowOutW-1:0]      s3_crow_q;
  logic [SqW-1:0]          s3_gx_sq_q, s3_gy_sq_q;
  logic signed [2*GradW-1:0] gx_sq_full, gy_sq_full;
  logic [SqW:0]            mag_sq;

  // output
  logic               out_v_q;
  pixel_t             out_edge_q;
  logic [ColOutW-1:0] out_ccol_q;
  logic [RowOutW-1:0] out_crow_q;
  logic               out_last_q;

  // flow control
  logic out_free, s3_free, s2_free, s1_free;
  logic s1_go, in_acc;

  assign out_free = !out_v_q || !out_stall_i;
  assign s3_free  = !s3_v_q || out_free;
  assign s2_free  = !s2_v_q || s3_free;
  assign s1_go    = s1_v_q && (!s1_has_q || s2_free);
  assign s1_free  = !s1_v_q || s1_go;
  assign in_acc   = in_valid_i && s1_free;
  assign in_stall_o = !s1_free;
  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q    <= ThresholdReset;
      image_width_q  <= WidthReset;
      image_height_q <= HeightReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgEdgeThreshold: threshold_q    <= cfg_data_i[ThrW-1:0];
        CfgImageWidth:    image_width_q  <= cfg_data_i;
        CfgImageHeight:   image_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    thr_sq_q <= ThrSqW'(threshold_q) * ThrSqW'(threshold_q);
  end

  // effective geometry and position of the incoming pixel
  always_comb begin
    if (image_width_q < MinDim) begin
      w_eff = WEW'(MinDim);
    end else if (32'(image_width_q) > MAX_WIDTH) begin
      w_eff = WEW'(MAX_WIDTH);
    end else begin
      w_eff = WEW'(image_width_q);
    end
    h_eff = (image_height_q < MinDim) ? MinDim : image_height_q;

    col_wrap = WEW'(col_q) >= w_eff;
    row_tmp  = col_wrap ? {1'b0, row_q} + 1'b1 : {1'b0, row_q};
    cur_row  = (row_tmp >= {1'b0, h_eff}) ? '0 : row_tmp[DimW-1:0];
    cur_col  = col_wrap ? '0 : col_q;

    col_inc = WEW'(cur_col) + 1'b1;
    row_inc = {1'b0, cur_row} + 1'b1;
    if (col_inc >= w_eff) begin
      col_d = '0;
      row_d = (row_inc >= {1'b0, h_eff}) ? '0 : row_inc[DimW-1:0];
    end else begin
      col_d = col_inc[CW-1:0];
      row_d = cur_row;
    end

    cur_has  = (cur_row >= DimW'(2)) && (CW'(cur_col) >= CW'(2));
    cur_last = (row_inc == {1'b0, h_eff}) && (col_inc == w_eff);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // line memory: read at accept, write back when stage 1 moves on
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_q <= line_mem[cur_col];
    end
    if (s1_go) begin
      line_mem[s1_col_q] <= {rd_q[PixW-1:0], s1_px_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_free) begin
      s1_v_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_has_q  <= cur_has;
      s1_last_q <= cur_last;
      s1_px_q   <= pixel_value_i;
      s1_col_q  <= cur_col;
      s1_ccol_q <= ColOutW'(cur_col - 1'b1);
      s1_crow_q <= cur_row - 1'b1;
    end
  end

  // window shift and gradients
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_d[i*3]     = win_q[i*3+1];
      win_d[i*3 + 1] = win_q[i*3+2];
    end
    win_d[2] = rd_q[2*PixW-1:PixW];
    win_d[5] = rd_q[PixW-1:0];
    win_d[8] = s1_px_q;

    gx_d = ($signed(GradW'(win_d[2])) - $signed(GradW'(win_d[0])))
         + (($signed(GradW'(win_d[5])) - $signed(GradW'(win_d[3]))) <<< 1)
         + ($signed(GradW'(win_d[8])) - $signed(GradW'(win_d[6])));
    gy_d = ($signed(GradW'(win_d[0])) + ($signed(GradW'(win_d[1])) <<< 1)
          + $signed(GradW'(win_d[2])))
         - ($signed(GradW'(win_d[6])) + ($signed(GradW'(win_d[7])) <<< 1)
          + $signed(GradW'(win_d[8])));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
    end else if (s1_go) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= win_d[i];
      end
    end
  end

  // stage 2: gradients
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s2_free) begin
      s2_v_q <= s1_go && s1_has_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_free && s1_go && s1_has_q) begin
      s2_gx_q   <= gx_d;
      s2_gy_q   <= gy_d;
      s2_ccol_q <= s1_ccol_q;
      s2_crow_q <= s1_crow_q;
      s2_last_q <= s1_last_q;
    end
  end

  // stage 3: squares
  assign gx_sq_full = s2_gx_q * s2_gx_q;
  assign gy_sq_full = s2_gy_q * s2_gy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (s3_free) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_free && s2_v_q) begin
      s3_gx_sq_q <= gx_sq_full[SqW-1:0];
      s3_gy_sq_q <= gy_sq_full[SqW-1:0];
      s3_ccol_q  <= s2_ccol_q;
      s3_crow_q  <= s2_crow_q;
      s3_last_q  <= s2_last_q;
    end
  end

  // output: compare against squared threshold
  assign mag_sq = {1'b0, s3_gx_sq_q} + {1'b0, s3_gy_sq_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_free) begin
      out_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s3_v_q) begin
      out_edge_q <= (ThrSqW'(mag_sq) > thr_sq_q) ? EdgeOn : EdgeOff;
      out_ccol_q <= s3_ccol_q;
      out_crow_q <= s3_crow_q;
      out_last_q <= s3_last_q;
    end
  end

  assign out_valid_o  = out_v_q;
  assign edge_value_o = out_edge_q;
  assign center_col_o = out_ccol_q;
  assign center_row_o = out_crow_q;
  assign frame_last_o = out_last_q;

endmodule
